[design/spp_pkg.sv]
// Shared constants, types and helper functions of the polyphonic sample player.
`default_nettype none
package spp_pkg;

   localparam int SAMPLE_DEPTH = 65536;
   localparam int VOICES       = 128;
   localparam int ADDR_W       = $clog2(SAMPLE_DEPTH);
   localparam int LEN_W        = ADDR_W + 1;
   localparam int VOICE_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int RATE_W       = 27;
   localparam int PROD_W       = 32 + RATE_W;
   localparam int RS_W         = PROD_W - 16;
   localparam int FIFO_DEPTH   = 4;
   localparam int DIV_SHIFT    = 37;
   localparam logic [30:0] DIV_MUL = 31'(((64'd1 << DIV_SHIFT) / 127) + 1);

   typedef enum logic [1:0] {
      ACT_TICK = 2'd0,
      ACT_ON   = 2'd1,
      ACT_OFF  = 2'd2,
      ACT_LOAD = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      CSR_BASE    = 2'd0,
      CSR_SUSTAIN = 2'd1,
      CSR_LENGTH  = 2'd2
   } csr_index_type;

   typedef struct packed {
      action_type         action;
      logic [6:0]         note;
      logic [6:0]         velocity;
      logic [15:0]        load_address;
      logic signed [15:0] load_value;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   function automatic logic [16:0] pitch_of(input logic [3:0] k);
      logic [16:0] r;
      case (k)
         4'd0:    r = 17'd65536;
         4'd1:    r = 17'd69433;
         4'd2:    r = 17'd73562;
         4'd3:    r = 17'd77936;
         4'd4:    r = 17'd82570;
         4'd5:    r = 17'd87480;
         4'd6:    r = 17'd92682;
         4'd7:    r = 17'd98193;
         4'd8:    r = 17'd104032;
         4'd9:    r = 17'd110218;
         4'd10:   r = 17'd116772;
         4'd11:   r = 17'd123715;
         default: r = 17'd65536;
      endcase
      return r;
   endfunction

   function automatic logic [RATE_W-1:0] rate_of(input logic [3:0] k,
                                                 input logic signed [4:0] oct);
      logic [RATE_W-1:0] r;
      r = RATE_W'(pitch_of(k));
      if (oct >= 0) r = r << oct;
      else          r = r >> (-oct);
      return r;
   endfunction

endpackage
`default_nettype wire

[design/spp_front.sv]
// Front end: accepts request transfers, drops ignored items, queues the rest.
`default_nettype none
module spp_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [47:0]       req_tdata,
   input  wire logic [1:0]        req_tuser,
   output spp_pkg::queue_head_type head,
   input  wire logic              pop
);
   import spp_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);

   item_type             q_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [PTR_W:0]       cnt_ff, cnt_in;
   item_type             item;
   logic                 keep, push;

   always_comb begin
      item.action       = action_type'(req_tuser);
      item.note         = req_tdata[6:0];
      item.velocity     = req_tdata[13:7];
      item.load_address = req_tdata[29:14];
      item.load_value   = req_tdata[45:30];
      unique case (item.action)
         ACT_TICK:        keep = 1'b1;
         ACT_ON, ACT_OFF: keep = 32'(item.note) < VOICES;
         ACT_LOAD:        keep = 32'(item.load_address) < SAMPLE_DEPTH;
         default:         keep = 1'b0;
      endcase
   end

   assign req_tready = cnt_ff != (PTR_W+1)'(FIFO_DEPTH);
   assign push       = req_tvalid && req_tready && keep;
   assign head.valid = cnt_ff != '0;
   assign head.item  = q_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ff] <= item;
   end

endmodule
`default_nettype wire

[design/spp_back.sv]
// Back end: configuration, voice state, sample memory, mixing walk and output register.
`default_nettype none
module spp_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire spp_pkg::queue_head_type head,
   output logic                        pop,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [1:0]             csr_index,
   input  wire logic [16:0]            csr_data,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [23:0]                 rsp_tdata
);
   import spp_pkg::*;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_WALK  = 5'b00010,
      ST_DRAIN = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_OUT   = 5'b10000
   } state_type;

   typedef struct packed {
      logic [31:0] onset;
      logic [6:0]  vel;
   } voice_type;

   state_type state_ff, state_in;

   logic [6:0]         base_ff, sustain_ff;
   logic [16:0]        length_ff;
   logic [31:0]        now_ff;
   logic [VOICES-1:0]  active_ff;

   logic signed [15:0] smem [SAMPLE_DEPTH];
   voice_type          vmem [VOICES];

   logic [VOICE_W-1:0] v_ff;
   logic [3:0]         k_ff;
   logic signed [4:0]  oct_ff;

   logic               vld_s1, vld_s2, vld_s3, vld_s4;
   voice_type          vq_s1;
   logic               act_s1, act_s2;
   logic [RATE_W-1:0]  rate_s1;
   logic [VOICE_W-1:0] v_s1, v_s2;
   logic [PROD_W-1:0]  prod_s2;
   logic [6:0]         vel_s2, vel_s3;
   logic               hit_s3;
   logic signed [15:0] smp_s3;
   logic signed [23:0] term_s4;
   logic signed [31:0] acc_ff;

   logic               neg_ff;
   logic [61:0]        dprod_ff;
   logic               out_valid_ff;
   logic [23:0]        out_data_ff;

   logic [LEN_W-1:0]   len;
   logic [7:0]         d0;
   logic [15:0]        d0q;
   logic [3:0]         q0;
   logic [31:0]        elapsed;
   logic [RS_W-1:0]    rs;
   logic               hit_s2, end_s2;
   logic [30:0]        acc_abs;
   logic [24:0]        quot;
   logic [23:0]        sat;
   logic               is_tick, start_walk;

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   assign len = (32'(length_ff) > SAMPLE_DEPTH) ? LEN_W'(SAMPLE_DEPTH) : LEN_W'(length_ff);
   assign d0  = 8'd132 - {1'b0, base_ff};
   assign d0q = 16'(d0) * 16'd171;
   assign q0  = d0q[14:11];

   assign is_tick    = head.item.action == ACT_TICK;
   assign pop        = (state_ff == ST_IDLE) && head.valid && !(is_tick && out_valid_ff);
   assign start_walk = pop && is_tick && (len != '0);

   assign elapsed = now_ff - vq_s1.onset;
   assign rs      = prod_s2[PROD_W-1:16];
   assign hit_s2  = act_s2 && (rs < RS_W'(len));
   assign end_s2  = vld_s2 && act_s2 && !hit_s2;

   assign acc_abs = acc_ff[31] ? 31'(-acc_ff) : acc_ff[30:0];
   assign quot    = dprod_ff[61:DIV_SHIFT];
   always_comb begin
      if (!neg_ff) sat = (quot > 25'd8388607) ? 24'h7FFFFF : quot[23:0];
      else         sat = (quot > 25'd8388608) ? 24'h800000 : 24'(-quot);
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (start_walk) state_in = ST_WALK;
         ST_WALK:  if (v_ff == VOICE_W'(VOICES - 1)) state_in = ST_DRAIN;
         ST_DRAIN: if (!vld_s1 && !vld_s2 && !vld_s3 && !vld_s4) state_in = ST_DIV;
         ST_DIV:   state_in = ST_OUT;
         ST_OUT:   state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= 7'd60;
         sustain_ff   <= '0;
         length_ff    <= '0;
         now_ff       <= '0;
         active_ff    <= '0;
         out_valid_ff <= 1'b0;
         vld_s1       <= 1'b0;
         vld_s2       <= 1'b0;
         vld_s3       <= 1'b0;
         vld_s4       <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_s1   <= state_ff == ST_WALK;
         vld_s2   <= vld_s1;
         vld_s3   <= vld_s2;
         vld_s4   <= vld_s3;
         if (csr_valid) begin
            case (csr_index_type'(csr_index))
               CSR_BASE:    base_ff    <= csr_data[6:0];
               CSR_SUSTAIN: sustain_ff <= csr_data[6:0];
               CSR_LENGTH:  length_ff  <= csr_data;
               default:     ;
            endcase
         end
         if (rsp_tready && state_ff != ST_OUT && !(pop && is_tick && len == '0))
            out_valid_ff <= 1'b0;
         if (end_s2) active_ff[v_s2] <= 1'b0;
         if (pop) begin
            case (head.item.action)
               ACT_TICK: begin
                  if (len == '0) begin
                     out_valid_ff <= 1'b1;
                     now_ff       <= now_ff + 32'd1;
                  end
               end
               ACT_ON:   active_ff[VOICE_W'(head.item.note)] <= head.item.velocity != '0;
               ACT_OFF:  if (sustain_ff == '0) active_ff[VOICE_W'(head.item.note)] <= 1'b0;
               default:  ;
            endcase
         end
         if (state_ff == ST_OUT) begin
            out_valid_ff <= 1'b1;
            now_ff       <= now_ff + 32'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head.item.action == ACT_LOAD)
         smem[ADDR_W'(head.item.load_address)] <= head.item.load_value;
      if (pop && head.item.action == ACT_ON && head.item.velocity != '0)
         vmem[VOICE_W'(head.item.note)] <= '{onset: now_ff, vel: head.item.velocity};
      if (pop && is_tick && len == '0) out_data_ff <= '0;
      if (start_walk) begin
         v_ff   <= '0;
         k_ff   <= 4'(d0 - 8'(q0) * 8'd12);
         oct_ff <= $signed({1'b0, q0}) - 5'sd11;
         acc_ff <= '0;
      end
      if (state_ff == ST_WALK) begin
         v_ff <= v_ff + 1'b1;
         if (k_ff == 4'd11) begin
            k_ff   <= '0;
            oct_ff <= oct_ff + 5'sd1;
         end else begin
            k_ff <= k_ff + 4'd1;
         end
      end
      vq_s1   <= vmem[v_ff];
      act_s1  <= active_ff[v_ff];
      rate_s1 <= rate_of(k_ff, oct_ff);
      v_s1    <= v_ff;
      prod_s2 <= PROD_W'(elapsed) * PROD_W'(rate_s1);
      act_s2  <= act_s1;
      vel_s2  <= vq_s1.vel;
      v_s2    <= v_s1;
      smp_s3  <= smem[rs[ADDR_W-1:0]];
      hit_s3  <= vld_s2 && hit_s2;
      vel_s3  <= vel_s2;
      term_s4 <= hit_s3 ? 24'(smp_s3 * $signed({1'b0, vel_s3})) : '0;
      if (vld_s4) acc_ff <= acc_ff + 32'(term_s4);
      if (state_ff == ST_DIV) begin
         neg_ff   <= acc_ff[31];
         dprod_ff <= 62'(acc_abs) * 62'(DIV_MUL);
      end
      if (state_ff == ST_OUT) out_data_ff <= sat;
   end

endmodule
`default_nettype wire

[design/polyphonic_sample_player_top.sv]
// Top level of the polyphonic sample player.
// Request channel (req_): one item per transfer; tuser carries the action
// (tick, note on, note off, load word), tdata the other fields.
// Response channel (rsp_): one mixed sample per tick, 24-bit signed.
// Configuration channel (csr_): index 0 base pitch, 1 sustain, 2 length;
// always ready, write only while the block is idle.
// Items enter a four-entry queue, so the request side takes up to four
// items while the back end works or the receiver stalls, then holds off.
// Note and load items are applied as they leave the queue. A tick walks all
// voices through the voice memory and a read/multiply pipeline, one voice
// a cycle, then drains the pipeline, scales the sum and registers the response.
// With length zero a tick is answered with a zero sample and no walk.
// A tick waits at the queue head while the previous response is not taken.
// Reset clears voice flags, the time counter and the queue, and sets base
// pitch 60, sustain 0, length 0. Sample memory is not cleared.
`default_nettype none
module polyphonic_sample_player_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // note, velocity, load_address, load_value
   input  wire logic [1:0]  req_tuser,   // action
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [23:0]      rsp_tdata,   // mix_out
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [16:0] csr_data
);
   import spp_pkg::*;

   queue_head_type head;
   logic           pop;

   spp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .head       (head),
      .pop        (pop)
   );

   spp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid) else $error("pop from empty queue");
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid) else $error("response valid after reset");
   a_tick_waits_rsp: assert property (@(posedge clock) disable iff (reset)
      pop && head.item.action == ACT_TICK |-> !rsp_tvalid)
      else $error("tick started while response pending");
`endif

endmodule
`default_nettype wire
